// ----- rtl/core/strfs_pkg.sv -----
package strfs_pkg;

	// fixed field widths of the stream items
	localparam int COORD_W    = 4;
	localparam int SIZE_W     = 5;
	localparam int IN_PIX_W   = 32;
	localparam int OUT_PIX_W  = 32;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USER_W = 1;

	// edge length after reset
	localparam logic [SIZE_W-1:0] TILE_SIZE_RESET = 5'd16;

	// operation carried in the input tuser
	typedef enum logic [IN_USER_W-1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_FLIP   = 2'd2,
		FUNC_ROTATE = 2'd3
	} func_t;

	// kept orientation: mirror flag over a count of quarter turns
	typedef struct packed {
		logic       mirror;
		logic [1:0] turns;
	} orient_t;

endpackage

// ----- rtl/core/square_tile_rotate_flip_store.sv -----
// Square tile store with rotate and mirror. The tile lives in one synchronous
// memory of MAX_DIM*MAX_DIM words; flip and rotate never move data, they update
// a kept orientation that remaps the column and row of every later access.
// One item is taken per clock while the input is ready: a read starts its
// memory access on the transfer and its result then moves into the output
// register once that register is free, and the input stalls only while a
// read result is blocked by a stalled output.
// A write or read outside tile_size columns or rows is bad: a write is dropped,
// a read returns pixel 0 with bad_coord set. tile_size above MAX_DIM acts as
// MAX_DIM, and a size of zero makes every coordinate bad. Reading a location
// that was never written returns an undefined word. No clearing pass is run.
module square_tile_rotate_flip_store #(
	parameter int MAX_DIM    = 16,
	parameter int PIXEL_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration: tile_size
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [strfs_pkg::SIZE_W-1:0]         cfg_data,
	// input items
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [strfs_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // col, row, pixel_in
	input  logic [strfs_pkg::IN_USER_W-1:0]      s_axis_tuser,   // func
	// result items
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [strfs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // pixel_out
	output logic [strfs_pkg::OUT_USER_W-1:0]     m_axis_tuser    // bad_coord
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = ($clog2(MAX_DIM + 1) > strfs_pkg::SIZE_W) ?
		$clog2(MAX_DIM + 1) : strfs_pkg::SIZE_W;
	localparam int XW    = (PIXEL_BITS > strfs_pkg::IN_PIX_W) ?
		PIXEL_BITS : strfs_pkg::IN_PIX_W;

	logic [strfs_pkg::SIZE_W-1:0]   tile_size_q;
	strfs_pkg::orient_t             orient_q;
	strfs_pkg::func_t               func;
	logic [strfs_pkg::COORD_W-1:0]  col;
	logic [strfs_pkg::COORD_W-1:0]  row;
	logic [strfs_pkg::IN_PIX_W-1:0] pixel_in;
	logic [DW-1:0]                  size_x;
	logic [DW-1:0]                  edge_n;
	logic [DW-1:0]                  edge_m1;
	logic [DW-1:0]                  c_x;
	logic [DW-1:0]                  r_x;
	logic [DW-1:0]                  pcol;
	logic [DW-1:0]                  prow;
	logic                           coord_ok;
	logic [AW-1:0]                  addr;
	logic [XW-1:0]                  pix_x;
	logic [PIXEL_BITS-1:0]          wr_word;
	logic                           in_xfer;
	logic                           wr_en;
	logic                           rd_en;
	logic                           move;

	logic [PIXEL_BITS-1:0]          mem [DEPTH];
	logic [PIXEL_BITS-1:0]          rdata_s1;
	logic                           pend_s1;
	logic                           bad_s1;
	logic [XW-1:0]                  rd_x;

	logic                           out_valid_q;
	logic [strfs_pkg::OUT_PIX_W-1:0] out_pix_q;
	logic                           out_bad_q;

	// unpack the input item
	assign func     = strfs_pkg::func_t'(s_axis_tuser);
	assign col      = s_axis_tdata[3:0];
	assign row      = s_axis_tdata[7:4];
	assign pixel_in = s_axis_tdata[39:8];

	// edge length in use, saturated to the memory's edge
	assign size_x  = DW'(tile_size_q);
	assign edge_n  = (size_x > DW'(MAX_DIM)) ? DW'(MAX_DIM) : size_x;
	assign edge_m1 = edge_n - DW'(1);
	assign c_x     = DW'(col);
	assign r_x     = DW'(row);
	assign coord_ok = (c_x < edge_n) && (r_x < edge_n);

	// logical to physical coordinates under the kept orientation
	always_comb begin
		logic [DW-1:0] tc;
		tc = c_x;
		prow = r_x;
		case (orient_q.turns)
			2'd0: begin
				tc   = c_x;
				prow = r_x;
			end
			2'd1: begin
				tc   = edge_m1 - r_x;
				prow = c_x;
			end
			2'd2: begin
				tc   = edge_m1 - c_x;
				prow = edge_m1 - r_x;
			end
			2'd3: begin
				tc   = r_x;
				prow = edge_m1 - c_x;
			end
			default: begin
				tc   = c_x;
				prow = r_x;
			end
		endcase
		pcol = orient_q.mirror ? (edge_m1 - tc) : tc;
	end

	assign addr = AW'(prow) * AW'(MAX_DIM) + AW'(pcol);

	// pixel word fitted to the stored width
	assign pix_x   = XW'(pixel_in);
	assign wr_word = pix_x[PIXEL_BITS-1:0];

	// handshake: a pending read may only advance into a free output register
	assign move          = pend_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !pend_s1 || move;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign wr_en         = in_xfer && (func == strfs_pkg::FUNC_WRITE) && coord_ok;
	assign rd_en         = in_xfer && (func == strfs_pkg::FUNC_READ) && coord_ok;

	// tile memory, one write or one read per transfer
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_word;
		end
		if (rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q <= strfs_pkg::TILE_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tile_size_q <= cfg_data;
		end
	end

	// orientation update on flip and rotate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= '0;
		end else if (in_xfer) begin
			case (func)
				strfs_pkg::FUNC_FLIP: begin
					orient_q.mirror <= !orient_q.mirror;
					orient_q.turns  <= 2'd0 - orient_q.turns;
				end
				strfs_pkg::FUNC_ROTATE: begin
					orient_q.turns <= orient_q.turns + 2'd1;
				end
				default: begin
					orient_q <= orient_q;
				end
			endcase
		end
	end

	// read stage: holds the read result until the output register takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (in_xfer && (func == strfs_pkg::FUNC_READ)) begin
			pend_s1 <= 1'b1;
		end else if (move) begin
			pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (func == strfs_pkg::FUNC_READ)) begin
			bad_s1 <= !coord_ok;
		end
	end

	// output register
	assign rd_x = XW'(rdata_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_pix_q <= bad_s1 ? '0 : rd_x[strfs_pkg::OUT_PIX_W-1:0];
			out_bad_q <= bad_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tuser  = out_bad_q;

endmodule
